>>> hdl/txc_pkg.sv
// Shared types and constants for the text console writer.
package txc_pkg;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;
  localparam int TAB_STOP_DEFAULT = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int MODE_W = 2;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 11;
  localparam int POS_W = 11;
  localparam int DATA_W = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [MODE_W-1:0] MODE_PUT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST_PRINTABLE = 8'h7F;

  localparam logic [CFG_INDEX_W-1:0] REG_CHAR_ATTRIBUTE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLANK_ATTRIBUTE = 1'd1;

  localparam logic [CFG_DATA_W-1:0] CHAR_ATTRIBUTE_RESET = 8'd1;
  localparam logic [CFG_DATA_W-1:0] BLANK_ATTRIBUTE_RESET = 8'd15;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_BACKSPACE,
    OP_TAB,
    OP_NEWLINE,
    OP_IGNORE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t op;
    logic [CHAR_W-1:0] char_code;
    logic [CELL_W-1:0] cell_index;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0] cursor_pos;
    logic [DATA_W-1:0] read_data;
  } result_t;

  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } cmd_side_t;

endpackage

>>> hdl/txc_queue.sv
// Small first-in first-out queue of fixed-width beats.
module txc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = txc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CntW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign dout = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/txc_front.sv
// Input side: accepts beats, classifies them into commands and queues them.
module txc_front #(
  parameter int COLUMNS = txc_pkg::COLUMNS_DEFAULT,
  parameter int ROWS = txc_pkg::ROWS_DEFAULT,
  parameter int QUEUE_DEPTH = txc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [txc_pkg::MODE_W-1:0]   mode,
  input  logic [txc_pkg::CHAR_W-1:0]   char_code,
  input  logic [txc_pkg::CELL_W-1:0]   cell_index,
  input  logic                         hold,
  input  logic                         cmd_pop,
  output txc_pkg::cmd_side_t           cmd_side
);

  localparam int CellCount = ROWS * COLUMNS;
  localparam int CmdW = $bits(txc_pkg::cmd_t);

  txc_pkg::cmd_t    cmd_in;
  logic             q_full;
  logic             q_empty;
  logic [CmdW-1:0]  q_dout;

  always_comb begin
    cmd_in.char_code = char_code;
    cmd_in.cell_index = cell_index;
    case (mode)
      txc_pkg::MODE_PUT: begin
        if (char_code == txc_pkg::CHAR_BACKSPACE) begin
          cmd_in.op = txc_pkg::OP_BACKSPACE;
        end else if (char_code == txc_pkg::CHAR_TAB) begin
          cmd_in.op = txc_pkg::OP_TAB;
        end else if (char_code == txc_pkg::CHAR_NEWLINE) begin
          cmd_in.op = txc_pkg::OP_NEWLINE;
        end else if (char_code inside {[txc_pkg::CHAR_SPACE:txc_pkg::CHAR_LAST_PRINTABLE]}) begin
          cmd_in.op = txc_pkg::OP_PRINT;
        end else begin
          cmd_in.op = txc_pkg::OP_IGNORE;
        end
      end
      txc_pkg::MODE_CLEAR: cmd_in.op = txc_pkg::OP_CLEAR;
      txc_pkg::MODE_READ: begin
        cmd_in.op = (32'(cell_index) < CellCount) ? txc_pkg::OP_READ : txc_pkg::OP_NOP;
      end
      default: cmd_in.op = txc_pkg::OP_NOP;
    endcase
  end

  assign full = q_full || hold;

  txc_queue #(
    .WIDTH(CmdW),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk(clk),
    .rst(rst),
    .push(push && !full),
    .din(cmd_in),
    .full(q_full),
    .pop(cmd_pop),
    .dout(q_dout),
    .empty(q_empty)
  );

  assign cmd_side = {q_empty, q_dout};

endmodule

>>> hdl/txc_back.sv
// Execution side: screen memory, cursor, scrolling, clearing and reads.
module txc_back #(
  parameter int COLUMNS = txc_pkg::COLUMNS_DEFAULT,
  parameter int ROWS = txc_pkg::ROWS_DEFAULT,
  parameter int TAB_STOP = txc_pkg::TAB_STOP_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [txc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [txc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  txc_pkg::cmd_side_t                cmd_side,
  output logic                              cmd_pop,
  output logic                              hold,
  input  logic                              res_full,
  output logic                              res_push,
  output txc_pkg::result_t                  res
);

  localparam int CellCount = ROWS * COLUMNS;
  localparam int CopyCount = (ROWS - 1) * COLUMNS;
  localparam int AddrW = $clog2(CellCount);
  localparam int CntW = $clog2(CellCount + 1);
  localparam int PosW = (AddrW > txc_pkg::POS_W) ? AddrW : txc_pkg::POS_W;
  localparam int ColW = $clog2(COLUMNS);
  localparam int RowW = $clog2(ROWS);
  localparam int ColNextW = $clog2(COLUMNS + TAB_STOP + 1);
  localparam int RowNextW = $clog2(ROWS + 1);
  localparam int TabCount = COLUMNS / TAB_STOP + 1;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_COPY,
    S_BLANK,
    S_DONE
  } state_t;

  logic [txc_pkg::DATA_W-1:0] screen [CellCount];

  state_t                       state;
  txc_pkg::cmd_t                cmd;
  logic [CntW-1:0]              cnt;
  logic [ColW-1:0]              col;
  logic [RowW-1:0]              row;
  logic [txc_pkg::DATA_W-1:0]   data;
  logic                         pend;
  logic [AddrW-1:0]             pend_addr;
  logic [txc_pkg::CFG_DATA_W-1:0] char_attribute;
  logic [txc_pkg::CFG_DATA_W-1:0] blank_attribute;

  logic [txc_pkg::DATA_W-1:0]   rdata;
  logic [AddrW-1:0]             rd_addr;
  logic                         mem_we;
  logic [AddrW-1:0]             mem_wa;
  logic [txc_pkg::DATA_W-1:0]   mem_wd;
  logic [PosW-1:0]              pos;
  logic [ColNextW-1:0]          tab_next;
  logic [ColNextW-1:0]          col_x;
  logic [RowNextW-1:0]          row_x;
  logic                         scroll;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_attribute <= txc_pkg::CHAR_ATTRIBUTE_RESET;
      blank_attribute <= txc_pkg::BLANK_ATTRIBUTE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        txc_pkg::REG_CHAR_ATTRIBUTE: char_attribute <= cfg_data;
        txc_pkg::REG_BLANK_ATTRIBUTE: blank_attribute <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos = PosW'(row) * PosW'(COLUMNS) + PosW'(col);

  always_comb begin
    tab_next = ColNextW'(TAB_STOP);
    for (int k = TabCount; k >= 1; k--) begin
      if (ColNextW'(k * TAB_STOP) > ColNextW'(col)) begin
        tab_next = ColNextW'(k * TAB_STOP);
      end
    end
  end

  always_comb begin
    col_x = ColNextW'(col);
    row_x = RowNextW'(row);
    case (cmd.op)
      txc_pkg::OP_BACKSPACE: begin
        if (col != '0) begin
          col_x = col_x - 1'b1;
        end
      end
      txc_pkg::OP_TAB: col_x = tab_next;
      txc_pkg::OP_NEWLINE: begin
        col_x = '0;
        row_x = row_x + 1'b1;
      end
      txc_pkg::OP_PRINT: col_x = col_x + 1'b1;
      default: ;
    endcase
    if (col_x >= ColNextW'(COLUMNS)) begin
      col_x = '0;
      row_x = row_x + 1'b1;
    end
    scroll = (row_x >= RowNextW'(ROWS));
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    rd_addr = AddrW'(cmd.cell_index);
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wa = cnt[AddrW-1:0];
      end
      S_EXEC: begin
        if (cmd.op == txc_pkg::OP_PRINT) begin
          mem_we = 1'b1;
          mem_wa = AddrW'(pos);
          mem_wd = {char_attribute, cmd.char_code};
        end
      end
      S_COPY: begin
        rd_addr = AddrW'(cnt + CntW'(COLUMNS));
        mem_we = pend;
        mem_wa = pend_addr;
        mem_wd = rdata;
      end
      S_BLANK: begin
        mem_we = 1'b1;
        mem_wa = cnt[AddrW-1:0];
        mem_wd = {blank_attribute, txc_pkg::CHAR_SPACE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_wa] <= mem_wd;
    end
    rdata <= screen[rd_addr];
  end

  assign cmd_pop = (state == S_IDLE) && !cmd_side.empty;
  assign hold = (state == S_INIT);
  assign res_push = (state == S_DONE) && !res_full;
  assign res.cursor_pos = txc_pkg::POS_W'(pos);
  assign res.read_data = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      cnt <= '0;
      col <= '0;
      row <= '0;
      pend <= 1'b0;
    end else begin
      case (state)
        S_INIT: begin
          if (cnt == CntW'(CellCount - 1)) begin
            cnt <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            cmd <= cmd_side.cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          data <= '0;
          case (cmd.op)
            txc_pkg::OP_CLEAR: begin
              cnt <= '0;
              col <= '0;
              row <= '0;
              state <= S_BLANK;
            end
            txc_pkg::OP_READ: state <= S_READ;
            txc_pkg::OP_NOP: state <= S_DONE;
            default: begin
              col <= ColW'(col_x);
              if (scroll) begin
                row <= RowW'(ROWS - 1);
                cnt <= '0;
                pend <= 1'b0;
                state <= S_COPY;
              end else begin
                row <= RowW'(row_x);
                state <= S_DONE;
              end
            end
          endcase
        end
        S_READ: begin
          data <= rdata;
          state <= S_DONE;
        end
        S_COPY: begin
          if (cnt < CntW'(CopyCount)) begin
            pend <= 1'b1;
            pend_addr <= cnt[AddrW-1:0];
            cnt <= cnt + 1'b1;
          end else begin
            pend <= 1'b0;
            state <= S_BLANK;
          end
        end
        S_BLANK: begin
          if (cnt == CntW'(CellCount - 1)) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/text_console_writer.sv
// Top level of the text console writer: command front, execution back and result queue.
//
//   Channel   Direction  Handshake             Beat contents
//   input     in         push / full           mode, char_code, cell_index
//   result    out        empty / pop           cursor_pos, read_data
//   config    in         cfg_write             cfg_index, cfg_data
//
// After reset the screen memory is cleared to zero, during which full stays high.
// A printed or control character passes through the idle, execute and result steps of
// the back end, and a read adds one step for the registered screen read.
// A scroll adds a copy step that moves each row up by one and a blanking step for the
// last row, and a clear blanks every cell. Commands and results queue separately, so a
// stalled pop does not stop the input side until both queues fill.
module text_console_writer #(
  parameter int COLUMNS = txc_pkg::COLUMNS_DEFAULT,
  parameter int ROWS = txc_pkg::ROWS_DEFAULT,
  parameter int TAB_STOP = txc_pkg::TAB_STOP_DEFAULT,
  parameter int QUEUE_DEPTH = txc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [txc_pkg::MODE_W-1:0]        mode,
  input  logic [txc_pkg::CHAR_W-1:0]        char_code,
  input  logic [txc_pkg::CELL_W-1:0]        cell_index,
  output logic                              empty,
  input  logic                              pop,
  output logic [txc_pkg::POS_W-1:0]         cursor_pos,
  output logic [txc_pkg::DATA_W-1:0]        read_data,
  input  logic                              cfg_write,
  input  logic [txc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [txc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ResW = $bits(txc_pkg::result_t);

  txc_pkg::cmd_side_t cmd_side;
  logic               cmd_pop;
  logic               hold;
  logic               res_full;
  logic               res_push;
  txc_pkg::result_t   res_in;
  txc_pkg::result_t   res_out;
  logic [ResW-1:0]    res_dout;

  txc_front #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .char_code(char_code),
    .cell_index(cell_index),
    .hold(hold),
    .cmd_pop(cmd_pop),
    .cmd_side(cmd_side)
  );

  txc_back #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd_side(cmd_side),
    .cmd_pop(cmd_pop),
    .hold(hold),
    .res_full(res_full),
    .res_push(res_push),
    .res(res_in)
  );

  txc_queue #(
    .WIDTH(ResW),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .din(res_in),
    .full(res_full),
    .pop(pop),
    .dout(res_dout),
    .empty(empty)
  );

  assign res_out = txc_pkg::result_t'(res_dout);
  assign cursor_pos = res_out.cursor_pos;
  assign read_data = res_out.read_data;

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the text console writer: queued stimulus, behavioural model, checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int COLS = txc_pkg::COLUMNS_DEFAULT;
  localparam int ROWS = txc_pkg::ROWS_DEFAULT;
  localparam int TAB = txc_pkg::TAB_STOP_DEFAULT;
  localparam int CELLS = ROWS * COLS;
  localparam int DRAIN_CYCLES = 2 * CELLS;
  localparam int PHASE_ITEMS = 220;
  localparam int HOLD_CYCLES = 500;
  localparam logic [txc_pkg::MODE_W-1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [txc_pkg::MODE_W-1:0] mode;
    logic [txc_pkg::CHAR_W-1:0] char_code;
    logic [txc_pkg::CELL_W-1:0] cell_index;
  } console_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [txc_pkg::MODE_W-1:0] mode = txc_pkg::MODE_PUT;
  logic [txc_pkg::CHAR_W-1:0] char_code = '0;
  logic [txc_pkg::CELL_W-1:0] cell_index = '0;
  logic empty;
  logic pop = 1'b0;
  logic [txc_pkg::POS_W-1:0] cursor_pos;
  logic [txc_pkg::DATA_W-1:0] read_data;
  logic cfg_write = 1'b0;
  logic [txc_pkg::CFG_INDEX_W-1:0] cfg_index = txc_pkg::REG_CHAR_ATTRIBUTE;
  logic [txc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  console_cmd_t cmd_backlog[$];
  txc_pkg::result_t screen_report_q[$];
  int mismatch_count = 0;

  logic [txc_pkg::DATA_W-1:0] screen_model [0:CELLS-1] = '{default: '0};
  int cur_col = 0;
  int cur_row = 0;
  logic [txc_pkg::CFG_DATA_W-1:0] text_attr = txc_pkg::CHAR_ATTRIBUTE_RESET;
  logic [txc_pkg::CFG_DATA_W-1:0] fill_attr = txc_pkg::BLANK_ATTRIBUTE_RESET;

  text_console_writer i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .char_code  (char_code),
    .cell_index (cell_index),
    .empty      (empty),
    .pop        (pop),
    .cursor_pos (cursor_pos),
    .read_data  (read_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic txc_pkg::result_t console_step(console_cmd_t c);
    txc_pkg::result_t r;
    int idx;
    r.read_data = '0;
    case (c.mode)
      txc_pkg::MODE_PUT: begin
        if (c.char_code == txc_pkg::CHAR_BACKSPACE) begin
          if (cur_col != 0) cur_col--;
        end else if (c.char_code == txc_pkg::CHAR_TAB) begin
          cur_col = (cur_col / TAB + 1) * TAB;
        end else if (c.char_code == txc_pkg::CHAR_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (c.char_code >= txc_pkg::CHAR_SPACE &&
                     c.char_code <= txc_pkg::CHAR_LAST_PRINTABLE) begin
          idx = cur_row * COLS + cur_col;
          if (idx < CELLS) screen_model[idx] = {text_attr, c.char_code};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
          for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
            screen_model[i] = {fill_attr, txc_pkg::CHAR_SPACE};
          cur_row = ROWS - 1;
        end
      end
      txc_pkg::MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = {fill_attr, txc_pkg::CHAR_SPACE};
        cur_col = 0;
        cur_row = 0;
      end
      txc_pkg::MODE_READ: begin
        if (int'(c.cell_index) < CELLS) r.read_data = screen_model[c.cell_index];
      end
      default: begin
      end
    endcase
    r.cursor_pos = txc_pkg::POS_W'(cur_row * COLS + cur_col);
    return r;
  endfunction

  function automatic console_cmd_t draw_cmd();
    console_cmd_t c;
    int pick;
    c.cell_index = txc_pkg::CELL_W'($urandom);
    c.char_code = txc_pkg::CHAR_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      c.mode = txc_pkg::MODE_CLEAR;
    end else if (pick < 6) begin
      c.mode = MODE_NONE;
    end else if (pick < 28) begin
      c.mode = txc_pkg::MODE_READ;
      pick = $urandom_range(0, 9);
      if (pick == 0)
        c.cell_index = txc_pkg::CELL_W'($urandom_range(CELLS, 2047));
      else if (pick < 5)
        c.cell_index = txc_pkg::CELL_W'($urandom_range(CELLS - 3 * COLS, CELLS - 1));
      else
        c.cell_index = txc_pkg::CELL_W'($urandom_range(0, CELLS - 1));
    end else begin
      c.mode = txc_pkg::MODE_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 8) c.char_code = txc_pkg::CHAR_BACKSPACE;
      else if (pick < 14) c.char_code = txc_pkg::CHAR_TAB;
      else if (pick < 24) c.char_code = txc_pkg::CHAR_NEWLINE;
      else if (pick < 28) c.char_code = txc_pkg::CHAR_W'($urandom_range(128, 255));
      else if (pick < 32) c.char_code = txc_pkg::CHAR_W'($urandom_range(11, 31));
      else c.char_code = txc_pkg::CHAR_W'($urandom_range(32, 127));
    end
    return c;
  endfunction

  task automatic add_cmd(logic [txc_pkg::MODE_W-1:0] m, logic [txc_pkg::CHAR_W-1:0] code,
                         logic [txc_pkg::CELL_W-1:0] cell_sel);
    console_cmd_t c;
    c.mode = m;
    c.char_code = code;
    c.cell_index = cell_sel;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_random(int count);
    console_cmd_t c;
    int made;
    int run;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        // A line of text, long enough at times to wrap.
        run = $urandom_range(5, 90);
        for (int k = 0; k < run; k++)
          add_cmd(txc_pkg::MODE_PUT, txc_pkg::CHAR_W'($urandom_range(32, 127)),
                  txc_pkg::CELL_W'($urandom));
        made += run;
        if ($urandom_range(0, 1) == 1) begin
          add_cmd(txc_pkg::MODE_PUT, txc_pkg::CHAR_NEWLINE, txc_pkg::CELL_W'($urandom));
          made++;
        end
      end else begin
        c = draw_cmd();
        cmd_backlog.push_back(c);
        if (c.mode != MODE_NONE && !(c.mode == txc_pkg::MODE_PUT &&
            c.char_code != txc_pkg::CHAR_BACKSPACE &&
            c.char_code != txc_pkg::CHAR_TAB && c.char_code != txc_pkg::CHAR_NEWLINE &&
            (c.char_code < txc_pkg::CHAR_SPACE || c.char_code > txc_pkg::CHAR_LAST_PRINTABLE)))
          made++;
      end
    end
  endtask

  task automatic write_reg(logic [txc_pkg::CFG_INDEX_W-1:0] idx,
                           logic [txc_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      txc_pkg::REG_CHAR_ATTRIBUTE: text_attr = value;
      txc_pkg::REG_BLANK_ATTRIBUTE: fill_attr = value;
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle_idle();
    while (cmd_backlog.size() != 0 || screen_report_q.size() != 0 || push) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    logic take;
    logic nxt;
    if (rst) begin
      push <= 1'b0;
    end else begin
      take = push && !full;
      if (take) begin
        screen_report_q.push_back(console_step(cmd_backlog[0]));
        void'(cmd_backlog.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) == 0) gap_left = 0;
          else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(10, 60);
          else gap_left = $urandom_range(1, 6);
        end
      end
      if (push && !take) begin
        nxt = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        nxt = 1'b0;
      end else begin
        nxt = (cmd_backlog.size() > 0);
      end
      push <= nxt;
      if (nxt) begin
        mode <= cmd_backlog[0].mode;
        char_code <= cmd_backlog[0].char_code;
        cell_index <= cmd_backlog[0].cell_index;
      end
    end
  end

  // Receiver: checks each result beat and stalls on a pattern of its own.
  int beats_done = 0;
  int stall_pct = 0;
  int pattern_left = 0;
  int hold_left = 0;
  logic [1:0] holds_fired = '0;

  always @(posedge clk) begin
    txc_pkg::result_t want;
    logic nxt;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (screen_report_q.size() == 0) begin
          $error("unexpected beat: cursor_pos %0d read_data 0x%04h", cursor_pos, read_data);
          mismatch_count++;
        end else begin
          want = screen_report_q.pop_front();
          if (cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, cursor_pos);
            mismatch_count++;
          end
          if (read_data !== want.read_data) begin
            $error("read_data: expected 0x%04h, got 0x%04h", want.read_data, read_data);
            mismatch_count++;
          end
        end
        beats_done++;
        if (beats_done == 150 && !holds_fired[0]) begin
          holds_fired[0] = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (beats_done == 600 && !holds_fired[1]) begin
          holds_fired[1] = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 90;
        endcase
      end else begin
        pattern_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else begin
        nxt = ($urandom_range(0, 99) >= stall_pct);
      end
      pop <= nxt;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_cmd(txc_pkg::MODE_READ, txc_pkg::CHAR_W'($urandom), 11'd0);
    add_cmd(txc_pkg::MODE_READ, txc_pkg::CHAR_W'($urandom), 11'd1999);
    add_cmd(txc_pkg::MODE_READ, txc_pkg::CHAR_W'($urandom), 11'd2047);
    add_cmd(MODE_NONE, 8'hFF, 11'd2000);
    add_cmd(txc_pkg::MODE_PUT, txc_pkg::CHAR_BACKSPACE, 11'd0);
    add_cmd(txc_pkg::MODE_PUT, txc_pkg::CHAR_SPACE, 11'h7FF);
    add_cmd(txc_pkg::MODE_PUT, txc_pkg::CHAR_LAST_PRINTABLE, 11'd0);
    add_cmd(txc_pkg::MODE_PUT, 8'h41, 11'd0);
    add_cmd(txc_pkg::MODE_PUT, txc_pkg::CHAR_BACKSPACE, 11'd0);
    add_cmd(txc_pkg::MODE_READ, 8'h00, 11'd1);
    add_cmd(txc_pkg::MODE_PUT, txc_pkg::CHAR_TAB, 11'd0);
    add_cmd(txc_pkg::MODE_PUT, txc_pkg::CHAR_NEWLINE, 11'd0);
    add_cmd(txc_pkg::MODE_PUT, 8'h00, 11'd0);
    add_cmd(txc_pkg::MODE_PUT, 8'h1F, 11'd0);
    add_cmd(txc_pkg::MODE_PUT, 8'h80, 11'd0);
    add_cmd(txc_pkg::MODE_PUT, 8'hFF, 11'd0);
    add_cmd(txc_pkg::MODE_CLEAR, 8'h00, 11'd0);
    add_cmd(txc_pkg::MODE_READ, 8'h00, 11'd1999);
    // Tabs run the cursor past the last column and wrap it to the next row.
    for (int k = 0; k < 10; k++) add_cmd(txc_pkg::MODE_PUT, txc_pkg::CHAR_TAB, 11'd0);
    add_cmd(txc_pkg::MODE_READ, 8'h00, 11'd0);
    settle_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(txc_pkg::REG_CHAR_ATTRIBUTE, 8'h00);
          write_reg(txc_pkg::REG_BLANK_ATTRIBUTE, 8'hFF);
        end
        1: begin
          write_reg(txc_pkg::REG_CHAR_ATTRIBUTE, 8'hFF);
          write_reg(txc_pkg::REG_BLANK_ATTRIBUTE, 8'h00);
        end
        default: begin
          write_reg(txc_pkg::REG_CHAR_ATTRIBUTE, txc_pkg::CFG_DATA_W'($urandom));
          write_reg(txc_pkg::REG_BLANK_ATTRIBUTE, txc_pkg::CFG_DATA_W'($urandom));
        end
      endcase
      @(negedge clk);
      queue_random(PHASE_ITEMS);
      settle_idle();
    end

    if (mismatch_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

>>> text_console_writer.f
hdl/txc_pkg.sv
hdl/txc_queue.sv
hdl/txc_front.sv
hdl/txc_back.sv
hdl/text_console_writer.sv
tb/sv/tb_top.sv
